@@ rtl/cwr_pkg.sv @@
// ----------------------------------------------------------------------------
// cwr_pkg: shared types and constants for the text console cell writer
// Field widths, opcodes, register indexes and the cell store request structs.
// ----------------------------------------------------------------------------
package cwr_pkg;

  localparam int LIN_W      = 14;  // linear position / cell count
  localparam int SW_W       = 15;  // sweep counter and store address
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CFG_COL_W  = 8;
  localparam int CFG_ROW_W  = 6;
  localparam int WORD_W     = 16;
  localparam int CIDX_W     = 12;
  localparam int OUT_LIN_W  = 13;

  localparam logic [1:0] OP_WRITE      = 2'd0;
  localparam logic [1:0] OP_SET_CURSOR = 2'd1;
  localparam logic [1:0] OP_CLEAR      = 2'd2;
  localparam logic [1:0] OP_READ       = 2'd3;

  localparam logic [1:0] REG_ATTRIBUTE = 2'd0;
  localparam logic [1:0] REG_COLUMNS   = 2'd1;
  localparam logic [1:0] REG_ROWS      = 2'd2;

  localparam logic [7:0]           NEWLINE    = 8'd10;
  localparam logic [7:0]           ATTR_RESET = 8'd7;
  localparam logic [CFG_COL_W-1:0] COLS_RESET = 8'd80;
  localparam logic [CFG_ROW_W-1:0] ROWS_RESET = 6'd25;

  typedef struct packed {
    logic              en;
    logic [SW_W-1:0]   addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic            en;
    logic [SW_W-1:0] addr;
  } mem_rd_t;

endpackage

@@ rtl/cwr_mac.sv @@
// ----------------------------------------------------------------------------
// cwr_mac: shared multiply-add unit
// q = a * b + c, registered. Used for cell count and cursor linear position.
// ----------------------------------------------------------------------------
module cwr_mac (
  input  logic                           clk,
  input  logic [cwr_pkg::CFG_ROW_W-1:0]  mul_a,
  input  logic [cwr_pkg::CFG_COL_W-1:0]  mul_b,
  input  logic [cwr_pkg::CFG_COL_W-1:0]  add_c,
  output logic [cwr_pkg::LIN_W-1:0]      q
);
  import cwr_pkg::*;

  logic [LIN_W-1:0] prod;

  assign prod = LIN_W'(mul_a) * LIN_W'(mul_b) + LIN_W'(add_c);

  always_ff @(posedge clk) begin
    q <= prod;
  end

endmodule

@@ rtl/cwr_mem.sv @@
// ----------------------------------------------------------------------------
// cwr_mem: character cell store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cwr_mem #(
  parameter int DEPTH = 4096
) (
  input  logic                        clk,
  input  cwr_pkg::mem_wr_t            wr,
  input  cwr_pkg::mem_rd_t            rd,
  output logic [cwr_pkg::WORD_W-1:0]  rdata
);
  import cwr_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd.en) begin
      rdata <= mem[rd.addr[AW-1:0]];
    end
  end

endmodule

@@ rtl/text_console_cell_writer_top.sv @@
// ----------------------------------------------------------------------------
// text_console_cell_writer_top: text-mode console cell writer
// One request at a time: in_stall stays high until its result is loaded into
// the output register; a clear or scroll adds a sweep (one cell per cycle).
// Reset: cursor 0,0, registers to defaults, then a zero pass over the store.
// ----------------------------------------------------------------------------
//
// Sequencer walk for one request:
//   CELLS  issue cols*rows on the shared multiply-add unit
//   POS    latch cell count, issue current cursor linear position
//   EXEC   store/read the cell, compute the new cursor, start a sweep if needed
//   SWEEP  clear or scroll, one cell per cycle (scroll reads cell+cols and
//          writes it back in the next cycle, so the store is read and written
//          in the same cycle)
//   DRAIN  last pipelined scroll write
//   LIN    issue new cursor linear position, capture read data
//   DONE   load the output register once it is free
// The store is not guarded by valid bits; after reset the sweep writes zero
// to every entry before the first request is taken.
module text_console_cell_writer_top #(
  parameter int MAX_COLS   = 128,
  parameter int MAX_ROWS   = 32,
  parameter int CELL_DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      opcode,
  input  logic [7:0]                      char_code,
  input  logic [cwr_pkg::COL_W-1:0]       target_col,
  input  logic [cwr_pkg::ROW_W-1:0]       target_row,
  input  logic [cwr_pkg::CIDX_W-1:0]      cell_index,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cwr_pkg::WORD_W-1:0]      read_word,
  output logic [cwr_pkg::COL_W-1:0]       cursor_col,
  output logic [cwr_pkg::ROW_W-1:0]       cursor_row,
  output logic [cwr_pkg::OUT_LIN_W-1:0]   cursor_linear,
  output logic                            cursor_on_screen,
  output logic                            did_scroll,
  output logic                            write_dropped,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [7:0]                      cfg_data
);
  import cwr_pkg::*;

  localparam logic [SW_W-1:0]        DEPTH_C    = SW_W'(CELL_DEPTH);
  localparam logic [CFG_COL_W:0]     MAX_COLS_C = (CFG_COL_W+1)'(MAX_COLS);
  localparam logic [CFG_ROW_W:0]     MAX_ROWS_C = (CFG_ROW_W+1)'(MAX_ROWS);

  typedef enum logic [2:0] {
    S_IDLE, S_CELLS, S_POS, S_EXEC, S_SWEEP, S_DRAIN, S_LIN, S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [7:0]           attribute;
  logic [CFG_COL_W-1:0] columns_in_use;
  logic [CFG_ROW_W-1:0] rows_in_use;

  // latched request
  logic [1:0]        req_op;
  logic [7:0]        req_char;
  logic [COL_W-1:0]  req_col;
  logic [ROW_W-1:0]  req_row;
  logic [CIDX_W-1:0] req_cidx;

  // cursor and per-request status
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [LIN_W-1:0]  cells;
  logic [LIN_W-1:0]  copy_end;
  logic              scrolled;
  logic              dropped;
  logic              rd_pending;
  logic [WORD_W-1:0] rd_word;

  // sweep engine
  logic [SW_W-1:0]   sweep_idx;
  logic [SW_W-1:0]   sweep_end;
  logic              sweep_copy;
  logic              sweep_boot;
  logic [WORD_W-1:0] sweep_fill;
  logic              p_we;
  logic              p_src_ok;
  logic [SW_W-1:0]   p_addr;

  // effective screen size, clamped
  logic [CFG_COL_W-1:0] cols_eff;
  logic [CFG_ROW_W-1:0] rows_eff;

  // shared unit hookup
  logic [CFG_ROW_W-1:0] mac_a;
  logic [CFG_COL_W-1:0] mac_c;
  logic [LIN_W-1:0]     mac_q;

  // store hookup
  mem_wr_t           mem_wr;
  mem_rd_t           mem_rd;
  logic [WORD_W-1:0] mem_rdata;

  // EXEC-stage decode
  logic [CFG_COL_W-1:0] x_inc;
  logic [CFG_ROW_W-1:0] y_inc;
  logic [CFG_COL_W-1:0] x_n;
  logic [CFG_ROW_W-1:0] y_n;
  logic [CFG_ROW_W-1:0] y_fin;
  logic                 is_newline;
  logic                 need_scroll;
  logic                 lin_ok;
  logic                 lin_in_depth;
  logic                 char_store;
  logic                 rd_ok;
  logic                 rd_in_depth;

  // sweep decode
  logic [SW_W-1:0] src;
  logic            src_ok;
  logic            idx_in_depth;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (columns_in_use == '0) begin
      cols_eff = CFG_COL_W'(1);
    end else if ({1'b0, columns_in_use} > MAX_COLS_C) begin
      cols_eff = MAX_COLS_C[CFG_COL_W-1:0];
    end else begin
      cols_eff = columns_in_use;
    end
    if (rows_in_use == '0) begin
      rows_eff = CFG_ROW_W'(1);
    end else if ({1'b0, rows_in_use} > MAX_ROWS_C) begin
      rows_eff = MAX_ROWS_C[CFG_ROW_W-1:0];
    end else begin
      rows_eff = rows_in_use;
    end
  end

  // CELLS: rows*cols; every other state: cursor position
  always_comb begin
    if (state == S_CELLS) begin
      mac_a = rows_eff;
      mac_c = '0;
    end else begin
      mac_a = {1'b0, cur_row};
      mac_c = {1'b0, cur_col};
    end
  end

  cwr_mac u_mac (
    .clk   (clk),
    .mul_a (mac_a),
    .mul_b (cols_eff),
    .add_c (mac_c),
    .q     (mac_q)
  );

  // next cursor; mac_q holds the old cursor's linear position in EXEC
  assign x_inc      = {1'b0, cur_col} + CFG_COL_W'(1);
  assign y_inc      = {1'b0, cur_row} + CFG_ROW_W'(1);
  assign is_newline = (req_char == NEWLINE);

  always_comb begin
    x_n = {1'b0, cur_col};
    y_n = {1'b0, cur_row};
    unique case (req_op)
      OP_WRITE: begin
        if (is_newline || (x_inc >= cols_eff)) begin
          x_n = '0;
          y_n = y_inc;
        end else begin
          x_n = x_inc;
        end
      end
      OP_SET_CURSOR: begin
        x_n = {1'b0, req_col};
        y_n = {1'b0, req_row};
      end
      OP_CLEAR: begin
        x_n = '0;
        y_n = '0;
      end
      OP_READ: begin
        x_n = {1'b0, cur_col};
        y_n = {1'b0, cur_row};
      end
      default: begin
        x_n = {1'b0, cur_col};
        y_n = {1'b0, cur_row};
      end
    endcase
  end

  assign need_scroll  = (req_op == OP_WRITE) && (y_n >= rows_eff);
  assign y_fin        = need_scroll ? (y_n - CFG_ROW_W'(1)) : y_n;
  assign lin_ok       = (mac_q < cells);
  assign lin_in_depth = ({1'b0, mac_q} < DEPTH_C);
  assign char_store   = (state == S_EXEC) && (req_op == OP_WRITE) && !is_newline &&
                        lin_ok && lin_in_depth;
  assign rd_ok        = (LIN_W'(req_cidx) < cells);
  assign rd_in_depth  = (SW_W'(req_cidx) < DEPTH_C);

  // scroll source is one row below the destination
  assign src          = sweep_idx + SW_W'(cols_eff);
  assign src_ok       = (sweep_idx < SW_W'(copy_end)) && (src < DEPTH_C);
  assign idx_in_depth = (sweep_idx < DEPTH_C);

  // write port: pipelined scroll write, clear fill, then character store
  always_comb begin
    mem_wr = '0;
    if (p_we) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = p_addr;
      mem_wr.data = p_src_ok ? mem_rdata : '0;
    end else if ((state == S_SWEEP) && !sweep_copy && idx_in_depth) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = sweep_idx;
      mem_wr.data = sweep_fill;
    end else if (char_store) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = SW_W'(mac_q);
      mem_wr.data = {attribute, req_char};
    end
  end

  always_comb begin
    mem_rd = '0;
    if ((state == S_SWEEP) && sweep_copy && src_ok) begin
      mem_rd.en   = 1'b1;
      mem_rd.addr = src;
    end else if ((state == S_EXEC) && (req_op == OP_READ) && rd_ok && rd_in_depth) begin
      mem_rd.en   = 1'b1;
      mem_rd.addr = SW_W'(req_cidx);
    end
  end

  cwr_mem #(
    .DEPTH (CELL_DEPTH)
  ) u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_SWEEP;       // zero pass over the whole store
      cur_col        <= '0;
      cur_row        <= '0;
      attribute      <= ATTR_RESET;
      columns_in_use <= COLS_RESET;
      rows_in_use    <= ROWS_RESET;
      sweep_idx      <= '0;
      sweep_end      <= DEPTH_C;
      sweep_copy     <= 1'b0;
      sweep_boot     <= 1'b1;
      sweep_fill     <= '0;
      p_we           <= 1'b0;
      rd_pending     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ATTRIBUTE: attribute      <= cfg_data;
          REG_COLUMNS:   columns_in_use <= cfg_data;
          REG_ROWS:      rows_in_use    <= cfg_data[CFG_ROW_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      p_we <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_op     <= opcode;
            req_char   <= char_code;
            req_col    <= target_col;
            req_row    <= target_row;
            req_cidx   <= cell_index;
            scrolled   <= 1'b0;
            dropped    <= 1'b0;
            rd_pending <= 1'b0;
            rd_word    <= '0;
            state      <= S_CELLS;
          end
        end
        S_CELLS: begin
          state <= S_POS;
        end
        S_POS: begin
          cells    <= mac_q;
          copy_end <= mac_q - LIN_W'(cols_eff);
          state    <= S_EXEC;
        end
        S_EXEC: begin
          cur_col <= x_n[COL_W-1:0];
          cur_row <= y_fin[ROW_W-1:0];
          // off-screen write still advances the cursor
          if ((req_op == OP_WRITE) && !is_newline && !lin_ok) begin
            dropped <= 1'b1;
          end
          if (req_op == OP_READ) begin
            dropped    <= !rd_ok;
            rd_pending <= rd_ok && rd_in_depth;
          end
          if ((req_op == OP_CLEAR) || need_scroll) begin
            sweep_idx  <= '0;
            sweep_end  <= SW_W'(cells);
            sweep_copy <= need_scroll;
            sweep_boot <= 1'b0;
            sweep_fill <= {attribute, 8'h00};
            scrolled   <= need_scroll;
            state      <= S_SWEEP;
          end else begin
            state <= S_LIN;
          end
        end
        S_SWEEP: begin
          p_we      <= sweep_copy && idx_in_depth;
          p_addr    <= sweep_idx;
          p_src_ok  <= src_ok;
          sweep_idx <= sweep_idx + SW_W'(1);
          if (sweep_idx == (sweep_end - SW_W'(1))) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= sweep_boot ? S_IDLE : S_LIN;
        end
        S_LIN: begin
          if (rd_pending) begin
            rd_word <= mem_rdata;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            read_word        <= rd_word;
            cursor_col       <= cur_col;
            cursor_row       <= cur_row;
            cursor_linear    <= mac_q[OUT_LIN_W-1:0];
            cursor_on_screen <= (mac_q < cells);
            did_scroll       <= scrolled;
            write_dropped    <= dropped;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result appeared outside DONE");

  a_write_in_store: assert property (@(posedge clk) disable iff (rst)
    mem_wr.en |-> (mem_wr.addr < DEPTH_C))
    else $error("store write beyond depth");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (sweep_idx < sweep_end))
    else $error("sweep index past end");

  a_scroll_write_follows_read: assert property (@(posedge clk) disable iff (rst)
    p_we |-> $past((state == S_SWEEP) && sweep_copy))
    else $error("scroll write without a sweep read cycle");
`endif

endmodule

@@ verif/cwr_checker.sv @@
// ----------------------------------------------------------------------------
// cwr_checker: scoreboard for the text console cell writer
// Watches the request, result and register channels, keeps a shadow screen
// and cursor, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module cwr_checker #(
  parameter int MAX_COLS   = 128,
  parameter int MAX_ROWS   = 32,
  parameter int CELL_DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [1:0]                      opcode,
  input  logic [7:0]                      char_code,
  input  logic [cwr_pkg::COL_W-1:0]       target_col,
  input  logic [cwr_pkg::ROW_W-1:0]       target_row,
  input  logic [cwr_pkg::CIDX_W-1:0]      cell_index,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [cwr_pkg::WORD_W-1:0]      read_word,
  input  logic [cwr_pkg::COL_W-1:0]       cursor_col,
  input  logic [cwr_pkg::ROW_W-1:0]       cursor_row,
  input  logic [cwr_pkg::OUT_LIN_W-1:0]   cursor_linear,
  input  logic                            cursor_on_screen,
  input  logic                            did_scroll,
  input  logic                            write_dropped,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [7:0]                      cfg_data,
  output int                              pending_results,
  output int                              mismatch_total
);
  import cwr_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0]    word;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic [OUT_LIN_W-1:0] lin;
    logic                 on_screen;
    logic                 scrolled;
    logic                 dropped;
  } console_result_t;

  logic [WORD_W-1:0]    shadow_screen [CELL_DEPTH];
  logic [COL_W-1:0]     cur_col;
  logic [ROW_W-1:0]     cur_row;
  logic [7:0]           attr_reg;
  logic [CFG_COL_W-1:0] cols_reg;
  logic [CFG_ROW_W-1:0] rows_reg;
  console_result_t      expected_results [$];
  int                   mismatch_cnt;

  function automatic logic [WORD_W-1:0] fetch_cell(int idx);
    if (idx < CELL_DEPTH) return shadow_screen[idx];
    return '0;
  endfunction

  function automatic void store_cell(int idx, logic [WORD_W-1:0] word);
    if (idx < CELL_DEPTH) shadow_screen[idx] = word;
  endfunction

  // Effective screen size: zero acts as one, oversize clamps to the maximum
  function automatic int screen_cols();
    int c;
    c = int'(cols_reg);
    if (c == 0) c = 1;
    if (c > MAX_COLS) c = MAX_COLS;
    return c;
  endfunction

  function automatic int screen_rows();
    int r;
    r = int'(rows_reg);
    if (r == 0) r = 1;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return r;
  endfunction

  // Apply one request to the shadow state and return the result it should give
  function automatic console_result_t predict_console(logic [1:0] op, logic [7:0] ch,
      logic [COL_W-1:0] tcol, logic [ROW_W-1:0] trow, logic [CIDX_W-1:0] cidx);
    console_result_t res;
    int cols, rows, cells, x, y, pos, r, c;
    cols  = screen_cols();
    rows  = screen_rows();
    cells = cols * rows;
    res   = '0;
    x     = int'(cur_col);
    y     = int'(cur_row);
    case (op)
      OP_WRITE: begin
        if (ch == NEWLINE) begin
          x = 0;
          y++;
        end else begin
          pos = x + y * cols;
          if (pos < cells) store_cell(pos, {attr_reg, ch});
          else res.dropped = 1'b1;
          x++;
          if (x >= cols) begin
            x = 0;
            y++;
          end
        end
        // scroll: rows 1..rows-1 move up, last row becomes zero words
        if (y >= rows) begin
          for (r = 1; r < rows; r++)
            for (c = 0; c < cols; c++)
              store_cell((r - 1) * cols + c, fetch_cell(r * cols + c));
          for (c = 0; c < cols; c++)
            store_cell((rows - 1) * cols + c, '0);
          y--;
          res.scrolled = 1'b1;
        end
      end
      OP_SET_CURSOR: begin
        x = int'(tcol);
        y = int'(trow);
      end
      OP_CLEAR: begin
        for (pos = 0; pos < cells; pos++) store_cell(pos, {attr_reg, 8'h00});
        x = 0;
        y = 0;
      end
      default: begin
        if (int'(cidx) < cells) res.word = fetch_cell(int'(cidx));
        else res.dropped = 1'b1;
      end
    endcase
    cur_col = x[COL_W-1:0];
    cur_row = y[ROW_W-1:0];
    pos = int'(cur_col) + int'(cur_row) * cols;
    res.col       = cur_col;
    res.row       = cur_row;
    res.lin       = pos[OUT_LIN_W-1:0];
    res.on_screen = (pos < cells);
    return res;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      if (mismatch_cnt < 10)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    console_result_t got;
    console_result_t want;
    if (rst) begin
      for (int i = 0; i < CELL_DEPTH; i++) shadow_screen[i] = '0;
      cur_col  = '0;
      cur_row  = '0;
      attr_reg = ATTR_RESET;
      cols_reg = COLS_RESET;
      rows_reg = ROWS_RESET;
      expected_results.delete();
      mismatch_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ATTRIBUTE: attr_reg = cfg_data;
          REG_COLUMNS:   cols_reg = cfg_data;
          REG_ROWS:      rows_reg = cfg_data[CFG_ROW_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{read_word, cursor_col, cursor_row, cursor_linear,
                cursor_on_screen, did_scroll, write_dropped};
        if (expected_results.size() == 0) begin
          if (mismatch_cnt < 10) $display("%0t: result with no request pending", $time);
          mismatch_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_word", int'(want.word), int'(got.word));
          check_field("cursor_col", int'(want.col), int'(got.col));
          check_field("cursor_row", int'(want.row), int'(got.row));
          check_field("cursor_linear", int'(want.lin), int'(got.lin));
          check_field("cursor_on_screen", int'(want.on_screen), int'(got.on_screen));
          check_field("did_scroll", int'(want.scrolled), int'(got.scrolled));
          check_field("write_dropped", int'(want.dropped), int'(got.dropped));
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_console(opcode, char_code, target_col,
                                                   target_row, cell_index));
    end
    pending_results <= expected_results.size();
    mismatch_total  <= mismatch_cnt;
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for text_console_cell_writer_top
// Drives console requests and register writes, stalls the result side at
// random, and leaves prediction and comparison to cwr_checker.
// ----------------------------------------------------------------------------
module tb;
  import cwr_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            opcode;
  logic [7:0]            char_code;
  logic [COL_W-1:0]      target_col;
  logic [ROW_W-1:0]      target_row;
  logic [CIDX_W-1:0]     cell_index;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [WORD_W-1:0]     read_word;
  logic [COL_W-1:0]      cursor_col;
  logic [ROW_W-1:0]      cursor_row;
  logic [OUT_LIN_W-1:0]  cursor_linear;
  logic                  cursor_on_screen;
  logic                  did_scroll;
  logic                  write_dropped;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [7:0]            cfg_data;

  int pending_results;
  int mismatch_total;

  // Idle percentages: request gaps (sender) and result stalls (receiver)
  int gap_pct   = 8;
  int stall_pct = 84;
  int random_sent;

  text_console_cell_writer_top dut (.*);
  cwr_checker                  chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side back-pressure; stall_pct changes by NBA so this edge sees a
  // stable value
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Hard stop. Worst case is every request sweeping a full 128x32 screen
  // behind long stalls; this is several times that.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Three idling regimes over the random part: slow receiver, slow sender,
  // then back to back.
  task automatic pick_idle();
    if (random_sent < 183) begin
      gap_pct   = 8;
      stall_pct <= 84;
    end else if (random_sent < 366) begin
      gap_pct   = 84;
      stall_pct <= 8;
    end else begin
      gap_pct   = 0;
      stall_pct <= 0;
    end
  endtask

  // One request; in_valid stays high across back-to-back requests and is only
  // lowered for a gap, so it never sees two NBAs in one step.
  task automatic send_req(logic [1:0] op, logic [7:0] ch, logic [COL_W-1:0] col,
                          logic [ROW_W-1:0] row, logic [CIDX_W-1:0] idx);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    char_code  <= ch;
    target_col <= col;
    target_row <= row;
    cell_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Block until every prediction has been matched. The first edge lets the
  // checker count the request accepted at this step.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Random request mix: mostly text (with newlines to reach the bottom and
  // scroll), some cursor moves and reads, rare clears. Unused fields carry
  // noise.
  task automatic random_req(int cols, int rows);
    int sel;
    logic [7:0]        ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CIDX_W-1:0] idx;
    sel = $urandom_range(99);
    ch  = 8'($urandom_range(255));
    col = COL_W'($urandom_range(127));
    row = ROW_W'($urandom_range(31));
    idx = CIDX_W'($urandom_range(4095));
    if (sel < 62) begin
      if ($urandom_range(99) < 20) ch = NEWLINE;
      send_req(OP_WRITE, ch, col, row, idx);
    end else if (sel < 72) begin
      // mostly on-screen targets, sometimes anywhere in the field range
      if ($urandom_range(99) < 80) begin
        col = COL_W'($urandom_range(cols - 1));
        row = ROW_W'($urandom_range(rows - 1));
      end
      send_req(OP_SET_CURSOR, ch, col, row, idx);
    end else if (sel < 75) begin
      send_req(OP_CLEAR, ch, col, row, idx);
    end else begin
      if ($urandom_range(99) < 75) idx = CIDX_W'($urandom_range(cols * rows - 1));
      send_req(OP_READ, ch, col, row, idx);
    end
  endtask

  // New screen setting once idle, then n random requests against it
  task automatic run_phase(logic [7:0] attr, logic [7:0] cols_cfg, logic [7:0] rows_cfg,
                           int n);
    int cols, rows;
    drain_results();
    write_reg(REG_ATTRIBUTE, attr);
    write_reg(REG_COLUMNS, cols_cfg);
    write_reg(REG_ROWS, rows_cfg);
    cfg_valid <= 1'b0;
    cols = (cols_cfg == 0) ? 1 : ((cols_cfg > 128) ? 128 : int'(cols_cfg));
    rows = (rows_cfg[5:0] == 0) ? 1 : ((rows_cfg[5:0] > 32) ? 32 : int'(rows_cfg[5:0]));
    repeat (n) begin
      pick_idle();
      random_req(cols, rows);
      random_sent++;
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    opcode      = OP_WRITE;
    char_code   = '0;
    target_col  = '0;
    target_row  = '0;
    cell_index  = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_ATTRIBUTE;
    cfg_data    = '0;
    random_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset screen (80x25, attribute 7). The block runs
    // its zeroing pass first; the handshake absorbs that.
    send_req(OP_READ, 8'h00, 7'd0, 5'd0, 12'd0);          // fresh store reads zero
    send_req(OP_WRITE, 8'h48, 7'd0, 5'd0, 12'd0);
    send_req(OP_WRITE, 8'hFF, 7'd0, 5'd0, 12'd0);
    send_req(OP_WRITE, 8'h00, 7'd0, 5'd0, 12'd0);
    send_req(OP_READ, 8'h00, 7'd0, 5'd0, 12'd0);
    send_req(OP_READ, 8'h00, 7'd0, 5'd0, 12'd1);
    send_req(OP_READ, 8'h00, 7'd0, 5'd0, 12'd2);
    send_req(OP_WRITE, NEWLINE, 7'd0, 5'd0, 12'd0);       // newline, no store
    // last cell: store, wrap past last row, scroll
    send_req(OP_SET_CURSOR, 8'h00, 7'd79, 5'd24, 12'd0);
    send_req(OP_WRITE, 8'h2A, 7'd0, 5'd0, 12'd0);
    send_req(OP_READ, 8'h00, 7'd0, 5'd0, 12'd1919);       // moved up one row
    send_req(OP_READ, 8'h00, 7'd0, 5'd0, 12'd1999);       // bottom row zeroed
    // cursor far off screen: dropped write, still advances and scrolls
    send_req(OP_SET_CURSOR, 8'h00, 7'd127, 5'd31, 12'd0);
    send_req(OP_WRITE, 8'h55, 7'd0, 5'd0, 12'd0);
    send_req(OP_WRITE, NEWLINE, 7'd0, 5'd0, 12'd0);
    // reads just past the screen and at the top of the index range
    send_req(OP_READ, 8'h00, 7'd0, 5'd0, 12'd2000);
    send_req(OP_READ, 8'h00, 7'd0, 5'd0, 12'd4095);
    send_req(OP_CLEAR, 8'h00, 7'd0, 5'd0, 12'd0);
    send_req(OP_READ, 8'h00, 7'd0, 5'd0, 12'd0);          // clear fill
    send_req(OP_SET_CURSOR, 8'h00, 7'd0, 5'd24, 12'd0);
    send_req(OP_WRITE, NEWLINE, 7'd0, 5'd0, 12'd0);       // newline scroll
    send_req(OP_SET_CURSOR, 8'h00, 7'd5, 5'd3, 12'd0);
    send_req(OP_WRITE, 8'h7E, 7'd0, 5'd0, 12'd0);
    send_req(OP_READ, 8'h00, 7'd0, 5'd0, 12'd245);

    // Random part over several screen settings, including the zero and
    // oversize extremes (which clamp) and one- and full-width/height screens.
    // The full 128x32 screen gets few requests since each sweep covers 4k cells.
    run_phase(8'h1E, 8'd80, 8'd25, 110);
    run_phase(8'hFF, 8'd0, 8'd0, 40);
    run_phase(8'h00, 8'd255, 8'hFF, 30);
    run_phase(8'hA5, 8'd16, 8'd8, 110);
    run_phase(8'h5A, 8'd1, 8'd32, 60);
    run_phase(8'hC3, 8'd128, 8'd1, 60);
    run_phase(8'h81, 8'd7, 8'd3, 140);

    drain_results();
    repeat (16) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
